### sv/kcp_pkg.sv
// ----------------------------------------------------------------------------
// kcp_pkg
// Types, constants and helpers for the kernel convolution pixel block.
// ----------------------------------------------------------------------------
`default_nettype none

package kcp_pkg;

	localparam int MAX_WIDTH      = 64;
	localparam int MAX_HEIGHT     = 64;
	localparam int MAX_KERNEL     = 7;
	localparam int COEF_FRAC_BITS = 8;

	localparam int COEF_DEPTH = MAX_KERNEL * MAX_KERNEL;
	localparam int FRAME_AW   = 12;
	localparam int COEF_AW    = 6;
	localparam int ACC_W      = 32;
	localparam int MAG_W      = ACC_W - 1;
	localparam int KSUM_W     = 24;
	localparam int STEP_W     = 5;

	// input commands
	localparam logic [1:0] CMD_COEF  = 2'd0;
	localparam logic [1:0] CMD_PIXEL = 2'd1;
	localparam logic [1:0] CMD_CONV  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_KCOLS  = 2'd2;
	localparam logic [1:0] REG_KROWS  = 2'd3;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [5:0]         pos_x;
		logic [5:0]         pos_y;
		logic [5:0]         coef_index;
		logic signed [15:0] coef_value;
		logic [7:0]         red_in;
		logic [7:0]         green_in;
		logic [7:0]         blue_in;
		logic [7:0]         alpha_in;
	} req_item_t;

	typedef struct packed {
		logic signed [15:0] red_out;
		logic signed [15:0] green_out;
		logic signed [15:0] blue_out;
		logic [7:0]         alpha_out;
		logic               in_range;
	} rsp_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TAPS,
		ST_DRAIN,
		ST_ALPHA,
		ST_DIV,
		ST_OUT
	} state_t;

	// image dimension register: zero acts as one, above the maximum as the maximum
	function automatic logic [6:0] clamp_dim(input logic [6:0] v, input logic [6:0] hi);
		logic [6:0] r;
		r = v;
		if (v == 7'd0)
			r = 7'd1;
		else if (v > hi)
			r = hi;
		return r;
	endfunction

	// kernel size register: zero acts as one
	function automatic logic [2:0] clamp_kern(input logic [2:0] v);
		return (v == 3'd0) ? 3'd1 : v;
	endfunction

	// apply sign to a quotient magnitude and saturate to 16 bits signed
	function automatic logic signed [15:0] sat_q(input logic [MAG_W-1:0] q,
		input logic neg);
		logic signed [15:0] r;
		logic [15:0]        lo;
		lo = q[15:0];
		if (neg) begin
			if (q > MAG_W'(32768))
				r = 16'sh8000;
			else
				r = $signed(-lo);
		end else begin
			if (q > MAG_W'(32767))
				r = 16'sh7fff;
			else
				r = $signed(lo);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### sv/kernel_convolution_pixel.sv
// ----------------------------------------------------------------------------
// kernel_convolution_pixel
// Frame store and kernel store with a normalized, zero padded convolution at
// one requested pixel.
// ----------------------------------------------------------------------------
//
// channel  | signals                          | direction
// ---------+----------------------------------+----------
// req      | req_valid, req_stall, req        | in
// rsp      | rsp_valid, rsp_stall, rsp        | out
// cfg      | cfg_valid, cfg_ready, cfg_index, | in
//          | cfg_data                         |
//
// A convolve request sweeps kernel_columns*kernel_rows taps (one multiply-
// accumulate per tap, one frame store read port), then divides the three
// channel sums in the shared restoring divider and presents the result.
// An out-of-image request skips the sweep and answers with an all-zero result.
// Reset clears control and configuration only; both stores hold garbage until
// written. req_stall is high while a request is being worked or its result
// waits on rsp_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module kernel_convolution_pixel
	import kcp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output      logic       req_stall,
	input  wire req_item_t  req,
	output      logic       rsp_valid,
	input  wire logic       rsp_stall,
	output      rsp_item_t  rsp,
	input  wire logic       cfg_valid,
	output      logic       cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [6:0] cfg_data
);

	// stores
	logic [31:0] frame_mem [0:(1<<FRAME_AW)-1];
	logic [15:0] coef_mem  [0:COEF_DEPTH-1];

	state_t state_q, state_d;

	logic [6:0] width_q, height_q;
	logic [2:0] kcols_q, krows_q;
	logic [6:0] w_eff, h_eff;
	logic [2:0] kc_eff, kr_eff;

	logic [5:0] px_q, py_q;
	logic [2:0] r_q, c_q;
	logic [COEF_AW-1:0] kidx_q;
	logic last_tap;

	logic [7:0] iy, ix;
	logic       tap_inb;
	logic [FRAME_AW-1:0] frame_raddr;
	logic [31:0] frame_rd_q;
	logic signed [15:0] coef_rd_q;
	logic tap_vld_s1, tap_inb_s1;

	logic signed [ACC_W-1:0]  acc_q [0:2];
	logic signed [KSUM_W-1:0] ksum_q;
	logic [7:0] alpha_q;

	logic [1:0]        ch_q;
	logic [STEP_W-1:0] step_q;
	logic [MAG_W-1:0]  dvd_q;
	logic [ACC_W-1:0]  rem_q;
	logic [ACC_W-1:0]  dsr;
	logic [ACC_W-1:0]  trial;
	logic              div_done;
	logic signed [15:0] res_q [0:2];

	logic req_acc, conv_start, conv_outside;
	logic signed [ACC_W-1:0] acc_sel;

	assign w_eff  = clamp_dim(width_q, 7'(MAX_WIDTH));
	assign h_eff  = clamp_dim(height_q, 7'(MAX_HEIGHT));
	assign kc_eff = clamp_kern(kcols_q);
	assign kr_eff = clamp_kern(krows_q);

	assign req_acc      = req_valid && !req_stall;
	assign conv_start   = req_acc && (req.cmd == CMD_CONV);
	assign conv_outside = ({1'b0, req.pos_x} >= w_eff) || ({1'b0, req.pos_y} >= h_eff);

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 7'd64;
			height_q <= 7'd64;
			kcols_q  <= 3'd3;
			krows_q  <= 3'd3;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_KCOLS:  kcols_q  <= cfg_data[2:0];
				REG_KROWS:  krows_q  <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// tap position relative to the request, negative shows in bit 7
	assign iy = {2'b0, py_q} + {5'b0, r_q} - {6'b0, kr_eff[2:1]};
	assign ix = {2'b0, px_q} + {5'b0, c_q} - {6'b0, kc_eff[2:1]};
	assign tap_inb = !iy[7] && (iy < {1'b0, h_eff}) && !ix[7] && (ix < {1'b0, w_eff});
	assign last_tap = (r_q == kr_eff - 3'd1) && (c_q == kc_eff - 3'd1);

	assign frame_raddr = (state_q == ST_TAPS) ? {iy[5:0], ix[5:0]} : {py_q, px_q};

	// store writes and registered reads
	always_ff @(posedge clk) begin
		if (req_acc && req.cmd == CMD_PIXEL)
			frame_mem[{req.pos_y, req.pos_x}] <= {req.alpha_in, req.blue_in,
				req.green_in, req.red_in};
		if (req_acc && req.cmd == CMD_COEF && req.coef_index < COEF_AW'(COEF_DEPTH))
			coef_mem[req.coef_index] <= req.coef_value;
		frame_rd_q <= frame_mem[frame_raddr];
		coef_rd_q  <= coef_mem[kidx_q];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (conv_start) state_d = conv_outside ? ST_OUT : ST_TAPS;
			ST_TAPS:  if (last_tap) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_ALPHA;
			ST_ALPHA: state_d = ST_DIV;
			ST_DIV:   if (div_done && ch_q == 2'd2) state_d = ST_OUT;
			ST_OUT:   if (!rsp_stall) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// handshake outputs
	always_comb begin
		req_stall = (state_q != ST_IDLE);
		rsp_valid = (state_q == ST_OUT);
	end

	// tap sweep counters and pipeline flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_vld_s1 <= 1'b0;
			tap_inb_s1 <= 1'b0;
		end else begin
			tap_vld_s1 <= (state_q == ST_TAPS);
			tap_inb_s1 <= (state_q == ST_TAPS) && tap_inb;
		end
	end

	always_ff @(posedge clk) begin
		if (conv_start) begin
			px_q   <= req.pos_x;
			py_q   <= req.pos_y;
			r_q    <= 3'd0;
			c_q    <= 3'd0;
			kidx_q <= '0;
		end else if (state_q == ST_TAPS) begin
			kidx_q <= kidx_q + COEF_AW'(1);
			if (c_q == kc_eff - 3'd1) begin
				c_q <= 3'd0;
				r_q <= r_q + 3'd1;
			end else begin
				c_q <= c_q + 3'd1;
			end
		end
	end

	// multiply-accumulate: kernel sum over every tap, channels over in-image taps
	always_ff @(posedge clk) begin
		if (conv_start) begin
			ksum_q <= '0;
			for (int k = 0; k < 3; k++)
				acc_q[k] <= '0;
		end else if (tap_vld_s1) begin
			ksum_q <= ksum_q + KSUM_W'(coef_rd_q);
			if (tap_inb_s1)
				for (int k = 0; k < 3; k++)
					acc_q[k] <= acc_q[k] + ACC_W'(coef_rd_q *
						$signed({1'b0, frame_rd_q[8*k +: 8]}));
		end
		if (state_q == ST_ALPHA)
			alpha_q <= frame_rd_q[31:24];
	end

	// shared restoring divider over the three channels
	assign dsr = (ksum_q == '0) ? ACC_W'(1 << COEF_FRAC_BITS) :
		ACC_W'(ksum_q[KSUM_W-1] ? -ksum_q : ksum_q);
	assign trial    = {rem_q[ACC_W-2:0], dvd_q[MAG_W-1]};
	assign div_done = (step_q == STEP_W'(MAG_W - 1));

	always_comb begin
		acc_sel = acc_q[0];
		case (ch_q)
			2'd0:    acc_sel = acc_q[1];
			2'd1:    acc_sel = acc_q[2];
			default: acc_sel = acc_q[0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ALPHA) begin
			ch_q   <= 2'd0;
			step_q <= '0;
			rem_q  <= '0;
			dvd_q  <= acc_q[0][ACC_W-1] ? MAG_W'(-acc_q[0]) : MAG_W'(acc_q[0]);
		end else if (state_q == ST_DIV) begin
			if (div_done) begin
				res_q[ch_q] <= sat_q({dvd_q[MAG_W-2:0], trial >= dsr},
					acc_q[ch_q][ACC_W-1] ^ ((ksum_q != '0) && ksum_q[KSUM_W-1]));
				ch_q   <= ch_q + 2'd1;
				step_q <= '0;
				rem_q  <= '0;
				dvd_q  <= acc_sel[ACC_W-1] ? MAG_W'(-acc_sel) : MAG_W'(acc_sel);
			end else begin
				step_q <= step_q + STEP_W'(1);
				if (trial >= dsr) begin
					rem_q <= trial - dsr;
					dvd_q <= {dvd_q[MAG_W-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					dvd_q <= {dvd_q[MAG_W-2:0], 1'b0};
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (conv_start && conv_outside) begin
			rsp <= '0;
		end else if (state_q == ST_DIV && state_d == ST_OUT) begin
			rsp.red_out   <= res_q[0];
			rsp.green_out <= res_q[1];
			rsp.blue_out  <= sat_q({dvd_q[MAG_W-2:0], trial >= dsr},
				acc_q[2][ACC_W-1] ^ ((ksum_q != '0) && ksum_q[KSUM_W-1]));
			rsp.alpha_out <= alpha_q;
			rsp.in_range  <= 1'b1;
		end
	end

endmodule

`default_nettype wire

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for kernel_convolution_pixel. It fills the coefficient
// store and a corner of the frame store, then sends directed and random
// coefficient loads, pixel stores and convolve requests over several register
// settings and idling mixes. Each result is checked field by field against an
// in-bench predictor of the filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
	import kcp_pkg::*;

	localparam int  CYCLE_LIMIT = 1500000;
	localparam int  SETTLE      = 200;
	// written corner of the frame store and the request area whose taps stay in it
	localparam int  FILL_SIZE   = 12;
	localparam int  SAFE_SIZE   = FILL_SIZE - MAX_KERNEL / 2;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       req_valid;
	logic       req_stall;
	req_item_t  req;
	logic       rsp_valid;
	logic       rsp_stall;
	rsp_item_t  rsp;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [6:0] cfg_data;

	// predictor state
	logic [31:0]        pixel_mem [MAX_WIDTH*MAX_HEIGHT];
	logic signed [15:0] coef_mem [COEF_DEPTH];
	logic [6:0]         width_reg, height_reg;
	logic [2:0]         kcols_reg, krows_reg;

	rsp_item_t pending_pixels[$];
	int        mismatches = 0;
	int        cycle_count = 0;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;
	int        hold_cycles = 0;

	kernel_convolution_pixel i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// receiver stall: long hold-off or random idling
	always @(posedge clk) begin
		if (hold_cycles > 0)
			hold_cycles--;
		rsp_stall <= (hold_cycles > 0) || ($urandom_range(99) < recv_idle_pct);
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		rsp_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_pixels.size() == 0) begin
				$error("result with nothing expected: %p", rsp);
				mismatches++;
			end else begin
				want = pending_pixels.pop_front();
				if (rsp.red_out !== want.red_out) begin
					$error("red_out expected %0d got %0d", want.red_out, rsp.red_out);
					mismatches++;
				end
				if (rsp.green_out !== want.green_out) begin
					$error("green_out expected %0d got %0d", want.green_out, rsp.green_out);
					mismatches++;
				end
				if (rsp.blue_out !== want.blue_out) begin
					$error("blue_out expected %0d got %0d", want.blue_out, rsp.blue_out);
					mismatches++;
				end
				if (rsp.alpha_out !== want.alpha_out) begin
					$error("alpha_out expected %0d got %0d", want.alpha_out, rsp.alpha_out);
					mismatches++;
				end
				if (rsp.in_range !== want.in_range) begin
					$error("in_range expected %0d got %0d", want.in_range, rsp.in_range);
					mismatches++;
				end
			end
		end
	end

	function automatic int eff_dim(input int v, input int hi);
		if (v == 0)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	// filtered value at (x,y) from the current stores and registers
	function automatic rsp_item_t filter_pixel(input logic [5:0] x, input logic [5:0] y);
		int                 w, h, kc, kr, iy, ix;
		longint             acc [3];
		longint             ksum, v;
		logic [31:0]        pix;
		logic signed [15:0] chan [3];
		rsp_item_t          res;
		w = eff_dim(width_reg, MAX_WIDTH);
		h = eff_dim(height_reg, MAX_HEIGHT);
		kc = eff_dim(kcols_reg, MAX_KERNEL);
		kr = eff_dim(krows_reg, MAX_KERNEL);
		res = '0;
		if (x >= w || y >= h)
			return res;
		ksum = 0;
		for (int i = 0; i < kc * kr; i++)
			ksum += coef_mem[i];
		acc = '{0, 0, 0};
		for (int r = 0; r < kr; r++) begin
			iy = int'(y) - kr / 2 + r;
			if (iy < 0 || iy >= h)
				continue;
			for (int c = 0; c < kc; c++) begin
				ix = int'(x) - kc / 2 + c;
				if (ix < 0 || ix >= w)
					continue;
				pix = pixel_mem[iy * MAX_WIDTH + ix];
				for (int ch = 0; ch < 3; ch++)
					acc[ch] += longint'(coef_mem[r * kc + c]) * longint'(pix[8*ch +: 8]);
			end
		end
		// zero kernel sum falls back to a plain Q7.8 scale
		for (int ch = 0; ch < 3; ch++) begin
			v = (ksum == 0) ? acc[ch] / 256 : acc[ch] / ksum;
			if (v > 32767)
				v = 32767;
			else if (v < -32768)
				v = -32768;
			chan[ch] = v[15:0];
		end
		res.red_out = chan[0];
		res.green_out = chan[1];
		res.blue_out = chan[2];
		res.alpha_out = pixel_mem[int'(y) * MAX_WIDTH + int'(x)][31:24];
		res.in_range = 1'b1;
		return res;
	endfunction

	// update the predictor for one accepted item
	task automatic predict_item(input req_item_t it);
		case (it.cmd)
			CMD_COEF: begin
				if (it.coef_index < COEF_DEPTH)
					coef_mem[it.coef_index] = it.coef_value;
			end
			CMD_PIXEL: begin
				pixel_mem[int'(it.pos_y) * MAX_WIDTH + int'(it.pos_x)] =
					{it.alpha_in, it.blue_in, it.green_in, it.red_in};
			end
			CMD_CONV: begin
				pending_pixels.push_back(filter_pixel(it.pos_x, it.pos_y));
			end
			default: ;
		endcase
	endtask

	// offer one item, with optional idle cycles ahead of it
	task automatic send_item(input req_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= it;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		predict_item(it);
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [6:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_WIDTH:  width_reg = data;
			REG_HEIGHT: height_reg = data;
			REG_KCOLS:  kcols_reg = data[2:0];
			REG_KROWS:  krows_reg = data[2:0];
			default: ;
		endcase
	endtask

	task automatic set_geometry(input int w, input int h, input int kc, input int kr);
		wait_idle();
		write_reg(REG_WIDTH, 7'(w));
		write_reg(REG_HEIGHT, 7'(h));
		write_reg(REG_KCOLS, 7'(kc));
		write_reg(REG_KROWS, 7'(kr));
		cfg_valid <= 1'b0;
	endtask

	function automatic req_item_t coef_item(input int idx, input int val);
		req_item_t it;
		it = req_item_t'($urandom_range(0, 32'hffff_ffff));
		it.cmd = CMD_COEF;
		it.coef_index = 6'(idx);
		it.coef_value = 16'(val);
		return it;
	endfunction

	function automatic req_item_t pixel_item(input int x, input int y, input logic [31:0] rgba);
		req_item_t it;
		it = req_item_t'($urandom);
		it.cmd = CMD_PIXEL;
		it.pos_x = 6'(x);
		it.pos_y = 6'(y);
		{it.alpha_in, it.blue_in, it.green_in, it.red_in} = rgba;
		return it;
	endfunction

	function automatic req_item_t conv_item(input int x, input int y);
		req_item_t it;
		it = req_item_t'({$urandom, $urandom});
		it.cmd = CMD_CONV;
		it.pos_x = 6'(x);
		it.pos_y = 6'(y);
		return it;
	endfunction

	// request inside the image folded into the written corner, outside left as is
	function automatic req_item_t safe_conv_item(input int x, input int y);
		int w, h;
		w = eff_dim(width_reg, MAX_WIDTH);
		h = eff_dim(height_reg, MAX_HEIGHT);
		if (x < w && y < h)
			return conv_item(x % SAFE_SIZE, y % SAFE_SIZE);
		return conv_item(x, y);
	endfunction

	// random item: requests, mostly inside the image, plus loads and some noise
	function automatic req_item_t random_item();
		req_item_t it;
		int        pick;
		int        w, h;
		pick = $urandom_range(99);
		w = eff_dim(width_reg, MAX_WIDTH);
		h = eff_dim(height_reg, MAX_HEIGHT);
		if (pick < 45) begin
			if ($urandom_range(9) < 8)
				it = safe_conv_item($urandom_range(w - 1), $urandom_range(h - 1));
			else
				it = safe_conv_item($urandom_range(63), $urandom_range(63));
		end else if (pick < 75)
			it = pixel_item($urandom_range(63), $urandom_range(63), $urandom);
		else if (pick < 95) begin
			if ($urandom_range(1))
				it = coef_item($urandom_range(63), $urandom_range(0, 16'hffff));
			else
				it = coef_item($urandom_range(48), int'($urandom_range(512)) - 128);
		end else begin
			it = req_item_t'({$urandom, $urandom});
			it.cmd = 2'd3;
		end
		return it;
	endfunction

	// store random pixels over a rectangle of positions
	task automatic fill_block(input int x0, input int y0, input int x1, input int y1);
		for (int y = y0; y <= y1; y++)
			for (int x = x0; x <= x1; x++)
				send_item(pixel_item(x, y, $urandom));
	endtask

	// all coefficients and the corner that requests read, so no unwritten entry is read
	task automatic fill_stores();
		for (int i = 0; i < COEF_DEPTH; i++)
			send_item(coef_item(i, int'($urandom_range(128))));
		fill_block(0, 0, FILL_SIZE - 1, FILL_SIZE - 1);
	endtask

	task automatic test_directed();
		// neighborhoods of the far corners read below
		fill_block(62, 62, 63, 63);
		fill_block(62, 0, 63, 1);
		fill_block(8, 18, 9, 19);
		// field extremes and corners
		send_item(pixel_item(0, 0, 32'hffff_ffff));
		send_item(pixel_item(63, 63, 32'h0000_0000));
		send_item(pixel_item(1, 0, 32'h00ff_00ff));
		send_item(conv_item(0, 0));
		send_item(conv_item(63, 63));
		send_item(conv_item(63, 0));
		// index beyond the store and unknown command are ignored
		send_item(coef_item(63, 16'h7fff));
		begin
			req_item_t junk;
			junk = req_item_t'({$urandom, $urandom});
			junk.cmd = 2'd3;
			send_item(junk);
		end
		// zero kernel sum
		for (int i = 0; i < 9; i++)
			send_item(coef_item(i, 0));
		send_item(coef_item(4, 256));
		send_item(coef_item(0, -256));
		send_item(conv_item(1, 1));
		// tiny positive then negative kernel sum forces saturation
		send_item(coef_item(0, 32767));
		send_item(coef_item(4, -32766));
		send_item(conv_item(1, 1));
		send_item(coef_item(4, -32768));
		send_item(conv_item(1, 1));
		send_item(coef_item(0, -32768));
		send_item(conv_item(2, 2));
		// requests outside the image and at its far corner
		set_geometry(10, 20, 3, 3);
		send_item(conv_item(10, 5));
		send_item(conv_item(3, 20));
		send_item(conv_item(9, 19));
	endtask

	task automatic run_random(input int count);
		repeat (count) send_item(random_item());
	endtask

	task automatic test_geometry_sweep();
		set_geometry(1, 1, 1, 1);
		run_random(25);
		set_geometry(64, 64, 7, 7);
		run_random(25);
		set_geometry(127, 0, 0, 7);
		run_random(25);
		set_geometry(0, 127, 7, 0);
		run_random(25);
		set_geometry(5, 3, 7, 2);
		run_random(25);
	endtask

	task automatic test_random_idling();
		send_idle_pct = 6;
		recv_idle_pct = 67;
		set_geometry($urandom_range(1, 64), $urandom_range(1, 64),
			$urandom_range(1, 7), $urandom_range(1, 7));
		run_random(100);
		send_idle_pct = 67;
		recv_idle_pct = 6;
		set_geometry($urandom_range(0, 127), $urandom_range(0, 127),
			$urandom_range(0, 7), $urandom_range(0, 7));
		run_random(100);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_geometry(64, 64, 3, 3);
		run_random(100);
	endtask

	task automatic test_backpressure();
		wait_idle();
		hold_cycles = 600;
		for (int i = 0; i < 8; i++)
			send_item(safe_conv_item($urandom_range(63), $urandom_range(63)));
		// sender pauses until every result is back
		req_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		run_random(20);
	endtask

	initial begin
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		rsp_stall <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_WIDTH;
		cfg_data <= '0;
		width_reg = 7'd64;
		height_reg = 7'd64;
		kcols_reg = 3'd3;
		krows_reg = 3'd3;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		fill_stores();
		test_directed();
		test_geometry_sweep();
		test_random_idling();
		test_backpressure();

		wait_idle();
		if (mismatches == 0 && pending_pixels.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
